FILE: sv/ecip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ecip_pkg;

  // parse phases
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ID      = 3'd1,
    PH_SIZE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DONE    = 3'd4,
    PH_HALT    = 3'd5
  } phase_e;

  // result kinds carried on the output tuser
  typedef enum logic [3:0] {
    KIND_FINISH      = 4'd0,
    KIND_SEGMENT     = 4'd1,
    KIND_SEEKHEAD    = 4'd2,
    KIND_TIMESCALE   = 4'd3,
    KIND_DURATION    = 4'd4,
    KIND_CUE_OPEN    = 4'd5,
    KIND_CUE_TIME    = 4'd6,
    KIND_CLUSTER_POS = 4'd7,
    KIND_TRACK       = 4'd8,
    KIND_BAD_HEADER  = 4'd9,
    KIND_BAD_LENGTH  = 4'd10
  } kind_e;

  // element ids, marker bit kept
  localparam logic [63:0] ID_EBML      = 64'h1A45DFA3;
  localparam logic [63:0] ID_SEGMENT   = 64'h18538067;
  localparam logic [63:0] ID_CLUSTER   = 64'h1F43B675;
  localparam logic [63:0] ID_SEEKHEAD  = 64'h114D9B74;
  localparam logic [63:0] ID_SEGINFO   = 64'h1549A966;
  localparam logic [63:0] ID_CUES      = 64'h1C53BB6B;
  localparam logic [63:0] ID_TIMESCALE = 64'h2AD7B1;
  localparam logic [63:0] ID_DURATION  = 64'h4489;
  localparam logic [63:0] ID_CUEPOINT  = 64'hBB;
  localparam logic [63:0] ID_CUETIME   = 64'hB3;
  localparam logic [63:0] ID_TRACKPOS  = 64'hB7;
  localparam logic [63:0] ID_CUETRACK  = 64'hF7;
  localparam logic [63:0] ID_CLUSTPOS  = 64'hF1;

  localparam logic [63:0] UNKNOWN_SIZE = 64'h7FFFFFFFFFFFFFFF;

  // bytes following the first byte of a vint (first byte nonzero)
  function automatic logic [2:0] vint_extra(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd7;
    for (int i = 1; i < 8; i++) begin
      if (b[i]) begin
        r = 3'(7 - i);
      end
    end
    return r;
  endfunction

  // kind reported at the end of a value payload
  function automatic kind_e payload_kind(input logic [63:0] id, input logic cue_nz);
    kind_e k;
    k = KIND_FINISH;
    if (id == ID_TIMESCALE) begin
      k = KIND_TIMESCALE;
    end else if (id == ID_DURATION) begin
      k = KIND_DURATION;
    end else if (cue_nz) begin
      if (id == ID_CUETIME) begin
        k = KIND_CUE_TIME;
      end else if (id == ID_CLUSTPOS) begin
        k = KIND_CLUSTER_POS;
      end else if (id == ID_CUETRACK) begin
        k = KIND_TRACK;
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ebml_cue_index_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// EBML / Matroska element parser for seek and cue information.
// Input: one container byte per transfer on s_axis, in file order, starting at
// the first byte of the file. The first four bytes must be the EBML header id.
// Output: one record per reported event on m_axis: tuser holds the kind,
// tdata holds the value (bits 63:0) and the running cue count (bits 95:64),
// tlast marks the record that ends parsing (cluster reached or cues consumed).
// Header mismatch and overlong vints give one error record, then the block
// swallows every further byte without output, as it does after finishing.
// A record is registered and appears on m_axis in the cycle after the byte that caused it.
// Each byte is one pass through the element step logic (vint decode, 64-bit
// position add and cues-end compare); one byte per cycle while s_axis_tready is high.
// The output register accepts a new byte while a record waits, as long as the
// receiver takes it in the same cycle; while the receiver stalls with a record
// pending, s_axis_tready is low and nothing is lost.
// Reset (rst_ni low) returns the parser to the header check with all counters
// and positions cleared and drops any pending record.
module ebml_cue_index_parser_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // data_byte[7:0]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,   // value[63:0], cue_index[95:64]
  output logic [3:0]        m_axis_tuser,   // kind[3:0]
  output logic              m_axis_tlast    // finished
);

  // parser state
  ecip_pkg::phase_e phase_q, phase_d;
  logic [1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [2:0]  vint_left_q, vint_left_d;
  logic [63:0] id_acc_q, id_acc_d;
  logic [63:0] size_acc_q, size_acc_d;
  logic        size_ones_q, size_ones_d;
  logic [63:0] payload_left_q, payload_left_d;
  logic [63:0] value_acc_q, value_acc_d;
  logic [63:0] stream_pos_q, stream_pos_d;
  logic [63:0] elem_start_q, elem_start_d;
  logic [63:0] cues_end_q, cues_end_d;
  logic        cues_end_valid_q, cues_end_valid_d;
  logic [31:0] cue_count_q, cue_count_d;

  // output register
  logic             out_valid_q, out_valid_d;
  ecip_pkg::kind_e  out_kind_q, out_kind_d;
  logic [63:0]      out_value_q, out_value_d;
  logic [31:0]      out_cue_q, out_cue_d;
  logic             out_fin_q, out_fin_d;

  // step decode
  logic        accept;
  logic [7:0]  b;
  logic [63:0] pos_inc;
  logic [2:0]  extra;
  logic [2:0]  vleft_new;
  logic [63:0] id_shift;
  logic [63:0] size_new;
  logic        ones_new;
  logic [63:0] size_eff;
  logic [64:0] cues_sum;
  logic [63:0] cues_sat;
  logic [63:0] pos_after_size;
  logic        is_container;
  logic        bad_len;
  logic        hdr_last;
  logic        hdr_bad;
  logic        size_done;
  logic        pay_done;
  logic        next_elem;
  logic [63:0] pos_cmp;
  logic [63:0] cend_cmp;
  logic        cvalid_cmp;
  logic        fin;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  // decode of the current byte against the parser state
  always_comb begin
    b         = s_axis_tdata;
    pos_inc   = stream_pos_q + 64'd1;
    extra     = ecip_pkg::vint_extra(b);
    vleft_new = (vint_left_q == 3'd0) ? extra : 3'(vint_left_q - 3'd1);
    id_shift  = {id_acc_q[55:0], b};
    if (vint_left_q == 3'd0) begin
      size_new = {56'd0, b ^ (8'h80 >> extra)};
      ones_new = (b == (8'hFF >> extra));
    end else begin
      size_new = {size_acc_q[55:0], b};
      ones_new = size_ones_q && (b == 8'hFF);
    end
    size_eff = ones_new ? ecip_pkg::UNKNOWN_SIZE : size_new;

    cues_sum = {1'b0, pos_inc} + {1'b0, size_eff};
    cues_sat = cues_sum[64] ? '1 : cues_sum[63:0];
    pos_after_size = (id_acc_q == ecip_pkg::ID_EBML) ? (pos_inc - elem_start_q) : pos_inc;

    is_container = (id_acc_q == ecip_pkg::ID_SEGMENT) || (id_acc_q == ecip_pkg::ID_SEGINFO) ||
                   (id_acc_q == ecip_pkg::ID_CUES) || (id_acc_q == ecip_pkg::ID_CUEPOINT) ||
                   (id_acc_q == ecip_pkg::ID_TRACKPOS);

    bad_len   = ((phase_q == ecip_pkg::PH_ID) || (phase_q == ecip_pkg::PH_SIZE)) &&
                (vint_left_q == 3'd0) && (b == 8'd0);
    hdr_last  = (phase_q == ecip_pkg::PH_HEADER) && (hdr_cnt_q == 2'd3);
    hdr_bad   = hdr_last && (id_shift != ecip_pkg::ID_EBML);
    size_done = (phase_q == ecip_pkg::PH_SIZE) && !bad_len && (vleft_new == 3'd0) &&
                (id_acc_q != ecip_pkg::ID_CLUSTER);
    pay_done  = (phase_q == ecip_pkg::PH_PAYLOAD) && (payload_left_q == 64'd1);

    // where the next element header starts, and the cues end test
    next_elem  = 1'b0;
    pos_cmp    = pos_inc;
    cend_cmp   = cues_end_q;
    cvalid_cmp = cues_end_valid_q;
    if (size_done) begin
      if (is_container) begin
        next_elem = 1'b1;
        if (id_acc_q == ecip_pkg::ID_CUES) begin
          cend_cmp   = cues_sat;
          cvalid_cmp = 1'b1;
        end
      end else if (size_eff == 64'd0) begin
        next_elem = 1'b1;
        pos_cmp   = pos_after_size;
      end
    end else if (pay_done) begin
      next_elem = 1'b1;
    end
    fin = next_elem && cvalid_cmp && (pos_cmp >= cend_cmp);
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        ecip_pkg::PH_HEADER: begin
          if (hdr_last) begin
            phase_d = hdr_bad ? ecip_pkg::PH_HALT : ecip_pkg::PH_SIZE;
          end
        end
        ecip_pkg::PH_ID: begin
          if (bad_len) begin
            phase_d = ecip_pkg::PH_HALT;
          end else if (vleft_new == 3'd0) begin
            phase_d = ecip_pkg::PH_SIZE;
          end
        end
        ecip_pkg::PH_SIZE: begin
          if (bad_len) begin
            phase_d = ecip_pkg::PH_HALT;
          end else if (vleft_new == 3'd0) begin
            if (id_acc_q == ecip_pkg::ID_CLUSTER) begin
              phase_d = ecip_pkg::PH_DONE;
            end else if (next_elem) begin
              phase_d = fin ? ecip_pkg::PH_DONE : ecip_pkg::PH_ID;
            end else begin
              phase_d = ecip_pkg::PH_PAYLOAD;
            end
          end
        end
        ecip_pkg::PH_PAYLOAD: begin
          if (pay_done) begin
            phase_d = fin ? ecip_pkg::PH_DONE : ecip_pkg::PH_ID;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // datapath updates and result forming
  always_comb begin
    ecip_pkg::kind_e k;
    logic            emit;
    logic [63:0]     v;
    logic            f;
    logic [63:0]     val_new;

    hdr_cnt_d        = hdr_cnt_q;
    vint_left_d      = vint_left_q;
    id_acc_d         = id_acc_q;
    size_acc_d       = size_acc_q;
    size_ones_d      = size_ones_q;
    payload_left_d   = payload_left_q;
    value_acc_d      = value_acc_q;
    stream_pos_d     = stream_pos_q;
    elem_start_d     = elem_start_q;
    cues_end_d       = cues_end_q;
    cues_end_valid_d = cues_end_valid_q;
    cue_count_d      = cue_count_q;
    k                = ecip_pkg::KIND_FINISH;
    emit             = 1'b0;
    v                = 64'd0;
    f                = 1'b0;
    val_new          = {value_acc_q[55:0], b};

    if (accept) begin
      case (phase_q)
        ecip_pkg::PH_HEADER: begin
          stream_pos_d = pos_inc;
          id_acc_d     = id_shift;
          if (!hdr_last) begin
            hdr_cnt_d = 2'(hdr_cnt_q + 2'd1);
          end else if (hdr_bad) begin
            emit = 1'b1;
            k    = ecip_pkg::KIND_BAD_HEADER;
          end else begin
            elem_start_d = 64'd0;
            vint_left_d  = 3'd0;
          end
        end
        ecip_pkg::PH_ID: begin
          if (bad_len) begin
            emit = 1'b1;
            k    = ecip_pkg::KIND_BAD_LENGTH;
          end else if (vint_left_q == 3'd0) begin
            elem_start_d = stream_pos_q;
            stream_pos_d = pos_inc;
            id_acc_d     = {56'd0, b};
            vint_left_d  = extra;
          end else begin
            stream_pos_d = pos_inc;
            id_acc_d     = id_shift;
            vint_left_d  = vleft_new;
          end
        end
        ecip_pkg::PH_SIZE: begin
          if (bad_len) begin
            emit = 1'b1;
            k    = ecip_pkg::KIND_BAD_LENGTH;
          end else begin
            stream_pos_d = pos_inc;
            size_ones_d  = ones_new;
            vint_left_d  = vleft_new;
            size_acc_d   = (vleft_new == 3'd0) ? size_eff : size_new;
            if (vleft_new == 3'd0) begin
              if (id_acc_q == ecip_pkg::ID_CLUSTER) begin
                // cluster header ends parsing
                emit = 1'b1;
                f    = 1'b1;
              end else if (is_container) begin
                if (id_acc_q == ecip_pkg::ID_SEGMENT) begin
                  k = ecip_pkg::KIND_SEGMENT;
                  v = elem_start_q;
                end else if (id_acc_q == ecip_pkg::ID_CUES) begin
                  cues_end_d       = cues_sat;
                  cues_end_valid_d = 1'b1;
                end else if (id_acc_q == ecip_pkg::ID_CUEPOINT) begin
                  if (cue_count_q != '1) begin
                    cue_count_d = cue_count_q + 32'd1;
                  end
                  k = ecip_pkg::KIND_CUE_OPEN;
                end
                f    = fin;
                emit = (k != ecip_pkg::KIND_FINISH) || fin;
              end else begin
                // value or skipped element
                stream_pos_d   = pos_after_size;
                value_acc_d    = 64'd0;
                payload_left_d = size_eff;
                if (id_acc_q == ecip_pkg::ID_SEEKHEAD) begin
                  k = ecip_pkg::KIND_SEEKHEAD;
                  v = elem_start_q;
                end else if (size_eff == 64'd0) begin
                  k = ecip_pkg::payload_kind(id_acc_q, cue_count_q != 32'd0);
                end
                f    = fin;
                emit = (k != ecip_pkg::KIND_FINISH) || fin;
              end
            end
          end
        end
        ecip_pkg::PH_PAYLOAD: begin
          stream_pos_d   = pos_inc;
          value_acc_d    = val_new;
          payload_left_d = payload_left_q - 64'd1;
          if (pay_done) begin
            k = ecip_pkg::payload_kind(id_acc_q, cue_count_q != 32'd0);
            if ((size_acc_q >= 64'd1) && (size_acc_q <= 64'd8)) begin
              v = val_new;
            end
            if (k == ecip_pkg::KIND_FINISH) begin
              v = 64'd0;
            end
            f    = fin;
            emit = (k != ecip_pkg::KIND_FINISH) || fin;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    // output register load
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_value_d = out_value_q;
    out_cue_d   = out_cue_q;
    out_fin_d   = out_fin_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = k;
      out_value_d = v;
      out_cue_d   = cue_count_d;
      out_fin_d   = f;
    end
  end

  // state and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= ecip_pkg::PH_HEADER;
      hdr_cnt_q        <= 2'd0;
      vint_left_q      <= 3'd0;
      id_acc_q         <= 64'd0;
      size_acc_q       <= 64'd0;
      size_ones_q      <= 1'b0;
      payload_left_q   <= 64'd0;
      value_acc_q      <= 64'd0;
      stream_pos_q     <= 64'd0;
      elem_start_q     <= 64'd0;
      cues_end_q       <= 64'd0;
      cues_end_valid_q <= 1'b0;
      cue_count_q      <= 32'd0;
      out_valid_q      <= 1'b0;
    end else begin
      phase_q          <= phase_d;
      hdr_cnt_q        <= hdr_cnt_d;
      vint_left_q      <= vint_left_d;
      id_acc_q         <= id_acc_d;
      size_acc_q       <= size_acc_d;
      size_ones_q      <= size_ones_d;
      payload_left_q   <= payload_left_d;
      value_acc_q      <= value_acc_d;
      stream_pos_q     <= stream_pos_d;
      elem_start_q     <= elem_start_d;
      cues_end_q       <= cues_end_d;
      cues_end_valid_q <= cues_end_valid_d;
      cue_count_q      <= cue_count_d;
      out_valid_q      <= out_valid_d;
    end
  end

  // record payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_kind_q  <= out_kind_d;
    out_value_q <= out_value_d;
    out_cue_q   <= out_cue_d;
    out_fin_q   <= out_fin_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_cue_q, out_value_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_fin_q;

endmodule

`default_nettype wire

FILE: sv/ecip_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ecip_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [95:0] m_axis_tdata,
  input wire logic [3:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // a stalled record holds its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output record changed while stalled");

  // nothing follows the record that ends parsing
  a_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("record after finish");

  // error records never end parsing and nothing follows them
  a_error_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ecip_pkg::KIND_BAD_HEADER ||
      m_axis_tuser == ecip_pkg::KIND_BAD_LENGTH) |-> !m_axis_tlast)
    else $error("error record marked last");

  a_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == ecip_pkg::KIND_BAD_HEADER ||
      m_axis_tuser == ecip_pkg::KIND_BAD_LENGTH) |=> !m_axis_tvalid)
    else $error("record after parse error");

  // records without a value carry zero
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ecip_pkg::KIND_FINISH ||
      m_axis_tuser == ecip_pkg::KIND_CUE_OPEN ||
      m_axis_tuser == ecip_pkg::KIND_BAD_HEADER ||
      m_axis_tuser == ecip_pkg::KIND_BAD_LENGTH) |-> m_axis_tdata[63:0] == 64'd0)
    else $error("nonzero value on a valueless record");

endmodule

bind ebml_cue_index_parser_unit ecip_checker u_ecip_checker (.*);

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

// one record as seen on the master side
typedef struct {
  ecip_pkg::kind_e kind;
  logic [63:0]     value;
  logic [31:0]     cue_index;
  logic            finished;
} parse_event_t;

// element walker that predicts the records, plus the in-order compare
class cue_parse_scoreboard;
  parse_event_t expected_events[$];
  int unsigned  errors;
  int unsigned  checked;
  int unsigned  kind_hits[16];

  ecip_pkg::phase_e phase;
  bit [2:0]    hdr_seen;
  bit [3:0]    vint_rem;
  bit [63:0]   id_word;
  bit [63:0]   size_word;
  bit [63:0]   bytes_left;
  bit [63:0]   val_word;
  bit [63:0]   pos;
  bit [63:0]   start_pos;
  bit [63:0]   cues_limit;
  bit          cues_limit_set;
  bit [31:0]   cues_opened;
  bit          size_all_ones;

  function new();
    phase = ecip_pkg::PH_HEADER;
    hdr_seen = '0;
    vint_rem = '0;
    id_word = '0;
    size_word = '0;
    bytes_left = '0;
    val_word = '0;
    pos = '0;
    start_pos = '0;
    cues_limit = '0;
    cues_limit_set = 1'b0;
    cues_opened = '0;
    size_all_ones = 1'b0;
    errors = 0;
    checked = 0;
    foreach (kind_hits[i]) kind_hits[i] = 0;
  endfunction

  function int unsigned pending();
    return expected_events.size();
  endfunction

  // leading zeros of the first byte give the vint length
  function int unsigned vint_bytes(bit [7:0] b);
    int unsigned n;
    n = 1;
    while (n < 8 && b[8 - n] == 1'b0) n++;
    return n;
  endfunction

  function void push_event(ecip_pkg::kind_e k, bit [63:0] v, bit fin);
    parse_event_t e;
    e.kind = k;
    e.value = v;
    e.cue_index = cues_opened;
    e.finished = fin;
    expected_events.push_back(e);
  endfunction

  // back to id parsing; true when the cues region is used up
  function bit next_elem();
    phase = ecip_pkg::PH_ID;
    vint_rem = '0;
    if (cues_limit_set && pos >= cues_limit) begin
      phase = ecip_pkg::PH_DONE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void finish_value();
    ecip_pkg::kind_e k;
    bit [63:0]       v;
    bit              fin;
    k = ecip_pkg::KIND_FINISH;
    v = (size_word >= 1 && size_word <= 8) ? val_word : 64'd0;
    if (id_word == ecip_pkg::ID_TIMESCALE) begin
      k = ecip_pkg::KIND_TIMESCALE;
    end else if (id_word == ecip_pkg::ID_DURATION) begin
      k = ecip_pkg::KIND_DURATION;
    end else if (cues_opened != 0) begin
      if (id_word == ecip_pkg::ID_CUETIME) k = ecip_pkg::KIND_CUE_TIME;
      else if (id_word == ecip_pkg::ID_CLUSTPOS) k = ecip_pkg::KIND_CLUSTER_POS;
      else if (id_word == ecip_pkg::ID_CUETRACK) k = ecip_pkg::KIND_TRACK;
    end
    fin = next_elem();
    if (k != ecip_pkg::KIND_FINISH || fin) begin
      push_event(k, (k != ecip_pkg::KIND_FINISH) ? v : 64'd0, fin);
    end
  endfunction

  function void finish_size();
    ecip_pkg::kind_e k;
    bit [63:0]       v;
    bit              fin;
    k = ecip_pkg::KIND_FINISH;
    v = '0;
    if (size_all_ones) size_word = ecip_pkg::UNKNOWN_SIZE;
    if (id_word == ecip_pkg::ID_CLUSTER) begin
      phase = ecip_pkg::PH_DONE;
      push_event(ecip_pkg::KIND_FINISH, 64'd0, 1'b1);
      return;
    end
    // master elements are entered, their size only matters for cues
    if (id_word == ecip_pkg::ID_SEGMENT || id_word == ecip_pkg::ID_SEGINFO ||
        id_word == ecip_pkg::ID_CUES || id_word == ecip_pkg::ID_CUEPOINT ||
        id_word == ecip_pkg::ID_TRACKPOS) begin
      if (id_word == ecip_pkg::ID_SEGMENT) begin
        k = ecip_pkg::KIND_SEGMENT;
        v = start_pos;
      end else if (id_word == ecip_pkg::ID_CUES) begin
        cues_limit = (size_word > ~pos) ? '1 : pos + size_word;
        cues_limit_set = 1'b1;
      end else if (id_word == ecip_pkg::ID_CUEPOINT) begin
        if (cues_opened != 32'hFFFF_FFFF) cues_opened++;
        k = ecip_pkg::KIND_CUE_OPEN;
      end
      fin = next_elem();
      if (k != ecip_pkg::KIND_FINISH || fin) push_event(k, v, fin);
      return;
    end
    if (id_word == ecip_pkg::ID_EBML) pos -= start_pos;
    if (id_word == ecip_pkg::ID_SEEKHEAD) begin
      k = ecip_pkg::KIND_SEEKHEAD;
      v = start_pos;
    end
    val_word = '0;
    bytes_left = size_word;
    if (bytes_left == 0) begin
      if (k != ecip_pkg::KIND_FINISH) begin
        fin = next_elem();
        push_event(k, v, fin);
      end else begin
        finish_value();
      end
      return;
    end
    phase = ecip_pkg::PH_PAYLOAD;
    if (k != ecip_pkg::KIND_FINISH) push_event(k, v, 1'b0);
  endfunction

  // one accepted stream byte
  function void note_byte(bit [7:0] b);
    int unsigned n;
    case (phase)
      ecip_pkg::PH_HEADER: begin
        pos++;
        id_word = {id_word[55:0], b};
        if (hdr_seen < 3) begin
          hdr_seen++;
        end else if (id_word != ecip_pkg::ID_EBML) begin
          phase = ecip_pkg::PH_HALT;
          push_event(ecip_pkg::KIND_BAD_HEADER, 64'd0, 1'b0);
        end else begin
          start_pos = '0;
          phase = ecip_pkg::PH_SIZE;
          vint_rem = '0;
        end
      end
      ecip_pkg::PH_ID: begin
        if (vint_rem == 0 && b == 8'h00) begin
          phase = ecip_pkg::PH_HALT;
          push_event(ecip_pkg::KIND_BAD_LENGTH, 64'd0, 1'b0);
        end else begin
          if (vint_rem == 0) begin
            start_pos = pos;
            id_word = {56'd0, b};
            vint_rem = 4'(vint_bytes(b) - 1);
          end else begin
            id_word = {id_word[55:0], b};
            vint_rem--;
          end
          pos++;
          if (vint_rem == 0) phase = ecip_pkg::PH_SIZE;
        end
      end
      ecip_pkg::PH_SIZE: begin
        if (vint_rem == 0 && b == 8'h00) begin
          phase = ecip_pkg::PH_HALT;
          push_event(ecip_pkg::KIND_BAD_LENGTH, 64'd0, 1'b0);
        end else begin
          if (vint_rem == 0) begin
            n = vint_bytes(b);
            size_word = {56'd0, b ^ (8'h80 >> (n - 1))};
            size_all_ones = (b == (8'hFF >> (n - 1)));
            vint_rem = 4'(n - 1);
          end else begin
            size_word = {size_word[55:0], b};
            size_all_ones = size_all_ones && (b == 8'hFF);
            vint_rem--;
          end
          pos++;
          if (vint_rem == 0) finish_size();
        end
      end
      ecip_pkg::PH_PAYLOAD: begin
        pos++;
        val_word = {val_word[55:0], b};
        bytes_left--;
        if (bytes_left == 0) finish_value();
      end
      default: begin
        // done or halted: byte is swallowed
      end
    endcase
  endfunction

  function void check_event(logic [3:0] kind, logic [63:0] value, logic [31:0] cue,
                            logic fin);
    parse_event_t e;
    if (expected_events.size() == 0) begin
      $display("%0t: record with nothing expected, kind %0d value %h cue %0d last %b",
               $time, kind, value, cue, fin);
      errors++;
      return;
    end
    e = expected_events.pop_front();
    checked++;
    kind_hits[e.kind]++;
    if (kind !== e.kind) begin
      $display("%0t: kind mismatch, expected %0d, got %0d", $time, e.kind, kind);
      errors++;
    end
    if (value !== e.value) begin
      $display("%0t: value mismatch, expected %h, got %h", $time, e.value, value);
      errors++;
    end
    if (cue !== e.cue_index) begin
      $display("%0t: cue index mismatch, expected %0d, got %0d", $time, e.cue_index, cue);
      errors++;
    end
    if (fin !== e.finished) begin
      $display("%0t: finished mismatch, expected %b, got %b", $time, e.finished, fin);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned STREAM_BYTES = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  cue_parse_scoreboard sb;
  bit [7:0]    stream_q[$];
  int unsigned tx_idle_pct = 13;
  int unsigned rx_idle_pct = 60;
  int unsigned cycles = 0;
  int unsigned ending;

  ebml_cue_index_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ebml_cue_index_parser_unit regression: fail");
      $finish;
    end
  end

  // result side: check each transfer, random backpressure
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_event(m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[95:64], m_axis_tlast);
    end
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // element ids are written with as many bytes as they need
  function automatic void put_id(bit [63:0] id);
    int nb;
    int i;
    nb = 8;
    while (nb > 1 && id[8*nb-1 -: 8] == 8'h00) nb--;
    for (i = nb - 1; i >= 0; i--) stream_q.push_back(id[8*i +: 8]);
  endfunction

  // size vint of len bytes, or the all-ones unknown size
  function automatic void put_size(bit [63:0] v, int len, bit unknown);
    bit [63:0] w;
    int i;
    if (unknown) w = (64'd1 << (7*len + 1)) - 1;
    else w = (64'd1 << (7*len)) | v;
    for (i = len - 1; i >= 0; i--) stream_q.push_back(w[8*i +: 8]);
  endfunction

  function automatic int rand_len();
    return ($urandom_range(9) < 7) ? 1 : $urandom_range(1, 8);
  endfunction

  // fill: 0 random, 1 zeros, 2 ones
  function automatic void put_elem(bit [63:0] id, int nbytes, int slen, int fill);
    int i;
    put_id(id);
    put_size(nbytes, slen, 1'b0);
    for (i = 0; i < nbytes; i++) begin
      case (fill)
        1: stream_q.push_back(8'h00);
        2: stream_q.push_back(8'hFF);
        default: stream_q.push_back(8'($urandom));
      endcase
    end
  endfunction

  function automatic int rand_fill();
    int r;
    r = $urandom_range(9);
    return (r == 0) ? 1 : (r == 1) ? 2 : 0;
  endfunction

  // value payload length: mostly 1..8, sometimes empty or too long
  function automatic int rand_value_len();
    if ($urandom_range(9) != 0) return $urandom_range(1, 8);
    return ($urandom_range(1) == 0) ? 0 : $urandom_range(9, 12);
  endfunction

  function automatic bit is_known(bit [63:0] id);
    return id == ecip_pkg::ID_EBML || id == ecip_pkg::ID_SEGMENT ||
           id == ecip_pkg::ID_CLUSTER || id == ecip_pkg::ID_SEEKHEAD ||
           id == ecip_pkg::ID_SEGINFO || id == ecip_pkg::ID_CUES ||
           id == ecip_pkg::ID_TIMESCALE || id == ecip_pkg::ID_DURATION ||
           id == ecip_pkg::ID_CUEPOINT || id == ecip_pkg::ID_CUETIME ||
           id == ecip_pkg::ID_TRACKPOS || id == ecip_pkg::ID_CUETRACK ||
           id == ecip_pkg::ID_CLUSTPOS;
  endfunction

  // id of an element the parser skips, 1 to 8 bytes
  function automatic bit [63:0] rand_id();
    int len;
    int i;
    bit [63:0] id;
    len = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
    id = $urandom_range((9'h100 >> (len - 1)) - 1, 8'h80 >> (len - 1));
    for (i = 1; i < len; i++) id = {id[55:0], 8'($urandom)};
    return is_known(id) ? 64'hEC : id;
  endfunction

  function automatic void build_stream();
    int r;
    int i;
    int n;
    // header element, then cue children before any cue point
    put_elem(ecip_pkg::ID_EBML, 3, 1, 0);
    put_elem(ecip_pkg::ID_CUETIME, 1, 1, 0);
    put_elem(ecip_pkg::ID_CLUSTPOS, 2, 1, 2);
    put_elem(ecip_pkg::ID_CUETRACK, 1, 1, 1);
    put_id(ecip_pkg::ID_SEGMENT);
    put_size(0, 8, 1'b1);
    put_elem(ecip_pkg::ID_SEEKHEAD, 0, 1, 0);
    put_elem(ecip_pkg::ID_SEEKHEAD, 2, 2, 0);
    put_id(ecip_pkg::ID_SEGINFO);
    put_size(0, 1, 1'b1);
    put_elem(ecip_pkg::ID_TIMESCALE, 8, 1, 2);
    put_elem(ecip_pkg::ID_TIMESCALE, 1, 8, 1);
    put_elem(ecip_pkg::ID_DURATION, 9, 1, 0);
    put_elem(ecip_pkg::ID_DURATION, 0, 1, 0);
    // repeated header restarts the position count
    put_elem(ecip_pkg::ID_EBML, 1, 1, 0);
    put_id(ecip_pkg::ID_CUES);
    put_size(0, 2, 1'b1);
    put_id(ecip_pkg::ID_CUEPOINT);
    put_size(0, 1, 1'b0);
    put_elem(ecip_pkg::ID_CUETIME, 8, 1, 0);
    put_id(ecip_pkg::ID_TRACKPOS);
    put_size(0, 4, 1'b1);
    put_elem(ecip_pkg::ID_CUETRACK, 1, 1, 2);
    put_elem(ecip_pkg::ID_CLUSTPOS, 3, 1, 0);

    // well formed cue region with random content
    while (stream_q.size() < STREAM_BYTES - 30) begin
      r = $urandom_range(99);
      if (r < 25) begin
        put_id(ecip_pkg::ID_CUEPOINT);
        put_size($urandom_range(40), rand_len(), $urandom_range(3) == 0);
      end else if (r < 45) begin
        put_elem(ecip_pkg::ID_CUETIME, rand_value_len(), rand_len(), rand_fill());
      end else if (r < 55) begin
        put_elem(ecip_pkg::ID_CLUSTPOS, rand_value_len(), rand_len(), rand_fill());
      end else if (r < 65) begin
        put_elem(ecip_pkg::ID_CUETRACK, rand_value_len(), rand_len(), rand_fill());
      end else if (r < 70) begin
        put_id(ecip_pkg::ID_TRACKPOS);
        put_size($urandom_range(20), rand_len(), $urandom_range(3) == 0);
      end else if (r < 74) begin
        put_elem(ecip_pkg::ID_TIMESCALE, rand_value_len(), rand_len(), rand_fill());
      end else if (r < 78) begin
        put_elem(ecip_pkg::ID_DURATION, rand_value_len(), rand_len(), rand_fill());
      end else if (r < 81) begin
        put_elem(ecip_pkg::ID_SEEKHEAD, $urandom_range(6), rand_len(), 0);
      end else if (r < 83) begin
        put_id(($urandom_range(1) == 0) ? ecip_pkg::ID_SEGMENT : ecip_pkg::ID_SEGINFO);
        // sizes up to 1000 need at least two vint bytes
        put_size($urandom_range(1000), $urandom_range(2, 8), $urandom_range(1) == 0);
      end else if (r < 84) begin
        put_elem(ecip_pkg::ID_EBML, $urandom_range(3), rand_len(), 0);
      end else begin
        put_elem(rand_id(), $urandom_range(12), rand_len(), rand_fill());
      end
    end

    // how the stream ends
    ending = $urandom_range(3);
    case (ending)
      0: begin
        put_id(ecip_pkg::ID_CLUSTER);
        put_size(0, rand_len(), 1'b1);
      end
      1: stream_q.push_back(8'h00);
      2: begin
        stream_q.push_back(8'hA0);
        stream_q.push_back(8'h00);
      end
      default: begin
        // sized cues region that closes on a cue time
        put_id(ecip_pkg::ID_CUES);
        put_size(6, 1, 1'b0);
        put_elem(ecip_pkg::ID_CUETIME, 4, 1, 0);
      end
    endcase
    // trailing bytes must be swallowed
    n = $urandom_range(8, 20);
    for (i = 0; i < n; i++) stream_q.push_back(8'($urandom));
  endfunction

  task automatic send_byte(bit [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(b);
  endtask

  // hold the sender until every record has been taken
  task automatic drain_records();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int n;
    int i;
    sb = new();
    build_stream();
    n = stream_q.size();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < n; i++) begin
      if (i == n / 3) begin
        drain_records();
        tx_idle_pct = 60;
        rx_idle_pct = 13;
      end else if (i == 2 * n / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_byte(stream_q[i]);
    end
    drain_records();
    repeat (20) @(posedge clk_i);

    $display("streamed %0d bytes, checked %0d records, %0d cue points opened",
             n, sb.checked, sb.cues_opened);
    $display("ending case %0d, finish records %0d, bad length records %0d",
             ending, sb.kind_hits[ecip_pkg::KIND_FINISH],
             sb.kind_hits[ecip_pkg::KIND_BAD_LENGTH]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ebml_cue_index_parser_unit regression: pass");
    end else begin
      $display("ebml_cue_index_parser_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: ebml_cue_index_parser_unit.f
sv/ecip_pkg.sv
sv/ebml_cue_index_parser_unit.sv
sv/ecip_checker.sv
bench/testbench.sv
